// ===== rtl/avm_pkg.sv =====
// Package: widths, operation codes and seven-segment table of the averaging voltmeter.
package avm_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int SEG_W        = 7;
  localparam int TENTHS_W     = 6;
  localparam int DIGIT_W      = 4;
  localparam int MEAN_DEFAULT = 4;
  localparam int SCALE_NUM    = 33;
  localparam int SCALE_DEN    = 1023;
  localparam int MAX_TENTHS   = 33;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'h77;
      4'd1:    code = 7'h41;
      4'd2:    code = 7'h3B;
      4'd3:    code = 7'h6B;
      4'd4:    code = 7'h4D;
      4'd5:    code = 7'h6E;
      4'd6:    code = 7'h7E;
      4'd7:    code = 7'h43;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/avm_item_if.sv =====
// Interfaces: input item channel and display result channel.
interface avm_item_if;
  import avm_pkg::*;
  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink (input valid, input operation, input sample, output ready);
endinterface

interface avm_result_if;
  import avm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;
  logic             point;
  logic             high_digit;

  modport source (output valid, output segments, output point, output high_digit, input ready);
  modport sink (input valid, input segments, input point, input high_digit, output ready);
endinterface

// ===== rtl/adc_average_voltmeter_7seg_top.sv =====
// Top level: sample averaging voltmeter driving a two-digit seven-segment display.
//
// Channel item carries one transaction per ADC sample (operation OP_SAMPLE) or per
// display refresh tick (operation OP_REFRESH). Channel result carries one transaction
// per refresh tick and none per sample: the segment pattern of one digit, its
// decimal point and the digit select. Digits alternate, units first (no point),
// then tens (point lit).
// Every SAMPLES_PER_MEAN samples the group mean is latched; refresh ticks show it
// in tenths of a volt, mean*33/1023 truncated.
// Throughput: one item per cycle when ready. Latency: a refresh result is valid
// the cycle after its item is taken; a group completed by a sample is visible
// to a refresh accepted in the next cycle. The result register decouples the
// sides: while a result waits, ready stays high if the receiver takes it in the
// same cycle, and drops only when the result register is full and not being taken.
// Reset (rst, synchronous): sum, sample count, latched mean and digit select clear,
// so the display shows 0.0 and the units digit comes first; no result is pending.
module adc_average_voltmeter_7seg_top #(
  parameter int SAMPLES_PER_MEAN = avm_pkg::MEAN_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  avm_item_if.sink    item,
  avm_result_if.source result
);
  import avm_pkg::*;

  localparam int SUM_W    = SAMPLE_W + $clog2(SAMPLES_PER_MEAN);
  localparam int CNT_W    = (SAMPLES_PER_MEAN > 1) ? $clog2(SAMPLES_PER_MEAN) : 1;
  localparam int DIV_SH   = SUM_W + 5;
  localparam int RECIP_W  = DIV_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int SCALED_W = SAMPLE_W + 6;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(SAMPLES_PER_MEAN) - 64'd1) / 64'(SAMPLES_PER_MEAN));
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_MEAN - 1);

  logic [SUM_W-1:0]    sum_acc;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    sample_count;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] mean_next;
  logic [PROD_W-1:0]   product;
  logic                digit_toggle;
  logic                accept;
  logic                is_refresh;
  logic                out_valid;
  logic [SEG_W-1:0]    out_segments;
  logic                out_high;

  logic [SCALED_W-1:0] scaled;
  logic [TENTHS_W-1:0] quot;
  logic [SAMPLE_W:0]   rem;
  logic [TENTHS_W-1:0] tenths;
  logic [TENTHS_W+6:0] tens_prod;
  logic [DIGIT_W-1:0]  tens;
  logic [DIGIT_W-1:0]  units;
  logic [SEG_W-1:0]    seg_next;

  assign item.ready  = !out_valid || result.ready;
  assign accept      = item.valid && item.ready;
  assign is_refresh  = (item.operation == OP_REFRESH);

  assign sum_next  = sum_acc + SUM_W'(item.sample);
  assign product   = PROD_W'(sum_next) * PROD_W'(RECIP);
  assign mean_next = product[DIV_SH +: SAMPLE_W];

  // scale by 33/1023: shift-add, then divide by 1024-1 with one correction
  assign scaled    = (SCALED_W'(mean) << 5) + SCALED_W'(mean);
  assign quot      = scaled[SCALED_W-1 -: TENTHS_W];
  assign rem       = {1'b0, scaled[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(quot);
  assign tenths    = quot + TENTHS_W'(rem >= (SAMPLE_W+1)'(SCALE_DEN));
  assign tens_prod = (TENTHS_W+7)'(tenths) * (TENTHS_W+7)'(13);
  assign tens      = DIGIT_W'(tens_prod >> 7);
  assign units     = DIGIT_W'(tenths - TENTHS_W'(tens) * TENTHS_W'(10));
  assign seg_next  = digit_toggle ? seg_of(tens) : seg_of(units);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc      <= '0;
      sample_count <= '0;
      mean         <= '0;
      digit_toggle <= 1'b0;
    end else if (accept) begin
      if (is_refresh) begin
        digit_toggle <= !digit_toggle;
      end else if (sample_count == LAST_CNT) begin
        mean         <= mean_next;
        sum_acc      <= '0;
        sample_count <= '0;
      end else begin
        sum_acc      <= sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (accept && is_refresh) || (out_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_refresh) begin
      out_segments <= seg_next;
      out_high     <= digit_toggle;
    end
  end

  assign result.valid      = out_valid;
  assign result.segments   = out_segments;
  assign result.point      = out_high;
  assign result.high_digit = out_high;

`ifndef ASSERT_OFF
  a_sample_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_refresh && (!out_valid || result.ready)) |=> !result.valid)
    else $error("sample transaction produced a result");

  a_refresh_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_refresh) |=> (result.valid && result.high_digit == $past(digit_toggle)))
    else $error("refresh transaction lost or wrong digit");

  a_toggle_flip: assert property (@(posedge clk) disable iff (rst)
    (accept && is_refresh) |=> (digit_toggle != $past(digit_toggle)))
    else $error("digit select did not alternate");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_CNT)
    else $error("sample count overran group");

  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    tenths <= TENTHS_W'(MAX_TENTHS))
    else $error("scaled voltage out of range");
`endif

endmodule

// ===== test/adc_average_voltmeter_7seg_checker.sv =====
// Checker: predicts the displayed digits from accepted items and compares every result.
module adc_average_voltmeter_7seg_checker #(
  parameter int SAMPLES_PER_MEAN = avm_pkg::MEAN_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  avm_item_if    item,
  avm_result_if  result,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import avm_pkg::*;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic             point;
    logic             high_digit;
  } digit_drive_t;

  digit_drive_t     expected_digits[$];
  logic [SEG_W-1:0] glyph_rom [0:9];
  int               acc_sum;
  int               acc_count;
  int               volt_tenths;
  logic             tens_next;

  initial begin
    glyph_rom[0] = 7'h77;
    glyph_rom[1] = 7'h41;
    glyph_rom[2] = 7'h3B;
    glyph_rom[3] = 7'h6B;
    glyph_rom[4] = 7'h4D;
    glyph_rom[5] = 7'h6E;
    glyph_rom[6] = 7'h7E;
    glyph_rom[7] = 7'h43;
    glyph_rom[8] = 7'h7F;
    glyph_rom[9] = 7'h6F;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
             want);
    fail_count++;
  endtask

  function automatic digit_drive_t drive_digit(input int tenths, input logic tens);
    digit_drive_t d;
    int           digit;
    digit        = tens ? tenths / 10 : tenths % 10;
    d.segments   = (digit < 10) ? glyph_rom[digit] : '0;
    d.point      = tens;
    d.high_digit = tens;
    return d;
  endfunction

  always @(posedge clk) begin
    digit_drive_t want;
    int           mean;
    if (rst) begin
      expected_digits.delete();
      acc_sum     = 0;
      acc_count   = 0;
      volt_tenths = 0;
      tens_next   = 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected transaction", result.segments, 0);
        end else begin
          want = expected_digits.pop_front();
          if (result.segments !== want.segments)
            report_mismatch("segments", result.segments, want.segments);
          if (result.point !== want.point)
            report_mismatch("point", result.point, want.point);
          if (result.high_digit !== want.high_digit)
            report_mismatch("high_digit", result.high_digit, want.high_digit);
        end
      end
      if (item.valid && item.ready) begin
        if (item.operation == OP_SAMPLE) begin
          acc_sum   = acc_sum + int'(item.sample);
          acc_count = acc_count + 1;
          if (acc_count >= SAMPLES_PER_MEAN) begin
            mean        = acc_sum / SAMPLES_PER_MEAN;
            volt_tenths = ((mean * SCALE_NUM) / SCALE_DEN) % 64;
            acc_sum     = 0;
            acc_count   = 0;
          end
        end else begin
          expected_digits.push_back(drive_digit(volt_tenths, tens_next));
          tens_next = ~tens_next;
        end
      end
    end
    pending = expected_digits.size();
  end

endmodule

// ===== test/adc_average_voltmeter_7seg_top_test.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module adc_average_voltmeter_7seg_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import avm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 430;
  localparam int HOLD_CYCLES  = 200;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   rx_hold_req;
  int   items_sent;

  avm_item_if   item_ch ();
  avm_result_if result_ch ();

  adc_average_voltmeter_7seg_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  adc_average_voltmeter_7seg_checker chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer(input op_t op, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.sample    <= smp;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    int phase_end;
    int base;
    int v;
    tx_pct = '{33, 84, 0};
    rx_pct = '{84, 33, 0};
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_SAMPLE;
    item_ch.sample    = '0;
    rx_hold_req       = 1'b0;
    items_sent        = 0;
    tx_idle_pct       = tx_pct[0];
    rx_idle_pct       = rx_pct[0];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // display before any group, full scale, mid-group refresh, mid scale, zero
    offer(OP_REFRESH, '0);
    offer(OP_REFRESH, '1);
    repeat (4) offer(OP_SAMPLE, 10'd1023);
    offer(OP_REFRESH, '0);
    offer(OP_REFRESH, '0);
    offer(OP_SAMPLE, 10'd0);
    offer(OP_REFRESH, '1);
    offer(OP_SAMPLE, 10'd1023);
    offer(OP_SAMPLE, 10'd512);
    offer(OP_SAMPLE, 10'd511);
    offer(OP_REFRESH, '0);
    offer(OP_REFRESH, '0);
    repeat (4) offer(OP_SAMPLE, 10'd0);
    offer(OP_REFRESH, '0);
    offer(OP_REFRESH, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pct[phase];
      rx_idle_pct = rx_pct[phase];
      if (phase == 2) begin
        rx_hold_req = 1'b1;
        repeat (30) offer(OP_REFRESH, 10'($urandom_range(0, 1023)));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(9) < 6) begin
          case ($urandom_range(7))
            0:       base = 0;
            1:       base = 1023;
            default: base = $urandom_range(0, 1023);
          endcase
          repeat (4) begin
            v = base + int'($urandom_range(0, 32)) - 16;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            offer(OP_SAMPLE, 10'(v));
          end
          offer(OP_REFRESH, 10'($urandom_range(0, 1023)));
          offer(OP_REFRESH, 10'($urandom_range(0, 1023)));
        end else begin
          offer($urandom_range(1) ? OP_REFRESH : OP_SAMPLE, 10'($urandom_range(0, 1023)));
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
